@@ sv/jac_pkg.sv @@
// Shared types and constants for the joystick axis conditioner.
// Used by jac_divider and joystick_axis_conditioner_core; no dependencies.
`timescale 1ns / 1ps

package jac_pkg;

  // Widths of the divider operands.
  localparam int unsigned DIVIDEND_W = 16;
  localparam int unsigned DIVISOR_W  = 8;
  localparam int unsigned DIV_STEP_W = 4;

  typedef logic [DIVIDEND_W-1:0] dividend_t;
  typedef logic [DIVISOR_W-1:0]  divisor_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_UPDATE_COUNT  = 3'd0;
  localparam logic [2:0] REG_CALIB_SAMPLES = 3'd1;
  localparam logic [2:0] REG_X_MINIMUM     = 3'd2;
  localparam logic [2:0] REG_X_MAXIMUM     = 3'd3;
  localparam logic [2:0] REG_Y_MINIMUM     = 3'd4;
  localparam logic [2:0] REG_Y_MAXIMUM     = 3'd5;
  localparam logic [2:0] REG_DEAD_ZONE     = 3'd6;

  // Configuration reset values.
  localparam logic [7:0] UPDATE_COUNT_RST  = 8'd10;
  localparam logic [7:0] CALIB_SAMPLES_RST = 8'd10;
  localparam logic [7:0] X_MINIMUM_RST     = 8'd68;
  localparam logic [7:0] X_MAXIMUM_RST     = 8'd248;
  localparam logic [7:0] Y_MINIMUM_RST     = 8'd65;
  localparam logic [7:0] Y_MAXIMUM_RST     = 8'd249;
  localparam logic [6:0] DEAD_ZONE_RST     = 7'd20;

  // Percent scaling and saturation.
  localparam logic [6:0] PERCENT_SCALE = 7'd100;
  localparam logic [6:0] PERCENT_MAX   = 7'd100;

  // Direction codes.
  localparam logic [2:0] DIR_NEUTRAL = 3'd0;
  localparam logic [2:0] DIR_UP      = 3'd1;
  localparam logic [2:0] DIR_DOWN    = 3'd2;
  localparam logic [2:0] DIR_LEFT    = 3'd3;
  localparam logic [2:0] DIR_RIGHT   = 3'd4;

endpackage

@@ sv/jac_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on jac_pkg for operand widths.
`timescale 1ns / 1ps

module jac_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  jac_pkg::dividend_t dividend,
  input  jac_pkg::divisor_t  divisor,
  output logic               done,
  output jac_pkg::dividend_t quotient
);

  logic                             busy;
  logic [jac_pkg::DIV_STEP_W-1:0]   step;
  logic [jac_pkg::DIVISOR_W-1:0]    rem;
  jac_pkg::dividend_t               quo;
  jac_pkg::divisor_t                dvs;

  logic [jac_pkg::DIVISOR_W:0]      shifted;
  logic [jac_pkg::DIVISOR_W:0]      trial;
  logic                             fits;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    shifted = {rem, quo[jac_pkg::DIVIDEND_W-1]};
    fits    = shifted >= {1'b0, dvs};
    trial   = shifted - {1'b0, dvs};
  end

  // Control: a run of exactly DIVIDEND_W steps, done pulses after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == jac_pkg::DIV_STEP_W'(jac_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and the dividend that shifts into the quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[jac_pkg::DIVISOR_W-1:0] : shifted[jac_pkg::DIVISOR_W-1:0];
      quo <= {quo[jac_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ sv/joystick_axis_conditioner_core.sv @@
// Joystick axis conditioner top level: sample accumulation, run sequencer,
// percent scaling and direction classification. Depends on jac_pkg, jac_divider.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall): one beat carries func, x_sample,
//   y_sample and button_pin. A beat that does not end a run is summed in the
//   cycle it is accepted, and the next beat may follow in the next cycle.
//   A beat that ends a run holds in_stall high while the sequencer runs up to
//   four divisions on one shared bit-serial divider (16 steps each; a skipped
//   division gives a zero result): two for the averages and, for an update
//   run, two for the axis percents. The next beat is taken once the result
//   has been loaded into the output register.
//   Output channel (out_valid / out_stall): one result beat per finished run,
//   held in an output register. Beats that do not end a run are still taken
//   while a result waits; a finished run waits in the last sequencer step
//   until the output register is free.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) is
//   always ready; write it only while the block is idle.
//   Reset (rst, synchronous) loads the register defaults, clears the sums,
//   count, run kind and zero points, and drops out_valid.

module joystick_axis_conditioner_core (
  input  logic              clk,
  input  logic              rst,
  // Input channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [7:0]        x_sample,
  input  logic [7:0]        y_sample,
  input  logic              button_pin,
  // Output channel.
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        x_average,
  output logic [7:0]        y_average,
  output logic signed [7:0] x_percent,
  output logic signed [7:0] y_percent,
  output logic [2:0]        direction,
  output logic              button_pressed,
  output logic              was_calibration,
  // Configuration port.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_X_AVG,
    PH_Y_AVG,
    PH_X_PCT,
    PH_Y_PCT
  } phase_t;

  // Configuration registers.
  logic [7:0] update_count;
  logic [7:0] calib_samples;
  logic [7:0] x_minimum;
  logic [7:0] x_maximum;
  logic [7:0] y_minimum;
  logic [7:0] y_maximum;
  logic [6:0] dead_zone;

  // Run state.
  state_t      state;
  phase_t      phase;
  logic [15:0] x_sum;
  logic [15:0] y_sum;
  logic [7:0]  sample_count;
  logic        run_mode;
  logic [7:0]  x_zero_point;
  logic [7:0]  y_zero_point;
  logic        zero_avg;
  logic        last_pressed;
  logic [7:0]  xa;
  logic [7:0]  ya;
  logic signed [7:0] xp;
  logic signed [7:0] yp;
  logic        pct_neg;

  // Accumulation signals.
  logic        in_accept;
  logic        mode_change;
  logic [15:0] x_sum_next;
  logic [15:0] y_sum_next;
  logic [7:0]  sample_count_next;
  logic [7:0]  target;
  logic        run_end;

  // Percent setup signals.
  logic [7:0]  pv;
  logic [7:0]  pz;
  logic [7:0]  plo;
  logic [7:0]  phi;
  logic        above;
  logic [7:0]  diff;
  logic [8:0]  span;
  logic        span_pos;
  logic [14:0] scaled;

  // Divider interface.
  logic                div_start;
  jac_pkg::dividend_t  div_dividend;
  jac_pkg::divisor_t   div_divisor;
  logic                div_done;
  jac_pkg::dividend_t  div_quotient;
  logic [6:0]          pct_mag;
  logic signed [7:0]   pct_value;

  // Classification signals.
  logic signed [8:0] dz;
  logic signed [8:0] xs9;
  logic signed [8:0] ys9;
  logic signed [8:0] ay;
  logic [2:0]        dir_calc;

  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      update_count  <= jac_pkg::UPDATE_COUNT_RST;
      calib_samples <= jac_pkg::CALIB_SAMPLES_RST;
      x_minimum     <= jac_pkg::X_MINIMUM_RST;
      x_maximum     <= jac_pkg::X_MAXIMUM_RST;
      y_minimum     <= jac_pkg::Y_MINIMUM_RST;
      y_maximum     <= jac_pkg::Y_MAXIMUM_RST;
      dead_zone     <= jac_pkg::DEAD_ZONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jac_pkg::REG_UPDATE_COUNT:  update_count  <= cfg_data;
        jac_pkg::REG_CALIB_SAMPLES: calib_samples <= cfg_data;
        jac_pkg::REG_X_MINIMUM:     x_minimum     <= cfg_data;
        jac_pkg::REG_X_MAXIMUM:     x_maximum     <= cfg_data;
        jac_pkg::REG_Y_MINIMUM:     y_minimum     <= cfg_data;
        jac_pkg::REG_Y_MAXIMUM:     y_maximum     <= cfg_data;
        jac_pkg::REG_DEAD_ZONE:     dead_zone     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Sum the new sample; a change of run kind restarts the sums and count.
  always_comb begin
    mode_change = (func != run_mode);
    if (mode_change) begin
      x_sum_next        = {8'd0, x_sample};
      y_sum_next        = {8'd0, y_sample};
      sample_count_next = 8'd1;
    end else begin
      x_sum_next        = x_sum + {8'd0, x_sample};
      y_sum_next        = y_sum + {8'd0, y_sample};
      sample_count_next = (sample_count == 8'hFF) ? sample_count : sample_count + 8'd1;
    end
    target  = func ? calib_samples : update_count;
    run_end = (target == 8'd0) || (sample_count_next >= target);
  end

  // Operands for one axis percent: offset from zero and span toward the limit.
  always_comb begin
    if (phase == PH_X_PCT) begin
      pv  = xa;
      pz  = x_zero_point;
      plo = x_minimum;
      phi = x_maximum;
    end else begin
      pv  = ya;
      pz  = y_zero_point;
      plo = y_minimum;
      phi = y_maximum;
    end
    above    = (pv >= pz);
    diff     = above ? (pv - pz) : (pz - pv);
    span     = above ? ({1'b0, phi} - {1'b0, pz}) : ({1'b0, pz} - {1'b0, plo});
    span_pos = !span[8] && (span != 9'd0);
    scaled   = 15'(diff) * 15'(jac_pkg::PERCENT_SCALE);
  end

  // Divider operand selection for the current phase.
  always_comb begin
    unique case (phase)
      PH_X_AVG: begin
        div_dividend = x_sum;
        div_divisor  = sample_count;
      end
      PH_Y_AVG: begin
        div_dividend = y_sum;
        div_divisor  = sample_count;
      end
      PH_X_PCT, PH_Y_PCT: begin
        div_dividend = {1'b0, scaled};
        div_divisor  = span[7:0];
      end
      default: begin
        div_dividend = x_sum;
        div_divisor  = sample_count;
      end
    endcase
    div_start = (state == ST_LOAD) &&
                (((phase == PH_X_AVG || phase == PH_Y_AVG) && !zero_avg) ||
                 ((phase == PH_X_PCT || phase == PH_Y_PCT) && span_pos));
  end

  // Saturated, signed percent from the divider quotient.
  always_comb begin
    pct_mag   = (div_quotient > {9'd0, jac_pkg::PERCENT_MAX}) ? jac_pkg::PERCENT_MAX
                                                              : div_quotient[6:0];
    pct_value = pct_neg ? -$signed({1'b0, pct_mag}) : $signed({1'b0, pct_mag});
  end

  // Direction with a deadzone; x wins ties.
  always_comb begin
    dz  = $signed({2'b00, dead_zone});
    xs9 = 9'(xp);
    ys9 = 9'(yp);
    ay  = (ys9 < 0) ? -ys9 : ys9;
    if (xs9 > dz && xs9 >= ay) begin
      dir_calc = jac_pkg::DIR_RIGHT;
    end else if (xs9 < -dz && -xs9 >= ay) begin
      dir_calc = jac_pkg::DIR_LEFT;
    end else if (ys9 > dz) begin
      dir_calc = jac_pkg::DIR_UP;
    end else if (ys9 < -dz) begin
      dir_calc = jac_pkg::DIR_DOWN;
    end else begin
      dir_calc = jac_pkg::DIR_NEUTRAL;
    end
  end

  jac_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Run sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_X_AVG;
      x_sum        <= '0;
      y_sum        <= '0;
      sample_count <= '0;
      run_mode     <= 1'b0;
      x_zero_point <= '0;
      y_zero_point <= '0;
      out_valid    <= 1'b0;
    end else begin
      // A taken result frees the register unless a new one loads this cycle.
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            run_mode     <= func;
            last_pressed <= !button_pin;
            x_sum        <= x_sum_next;
            y_sum        <= y_sum_next;
            sample_count <= sample_count_next;
            if (run_end) begin
              zero_avg <= (target == 8'd0);
              phase    <= PH_X_AVG;
              state    <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          pct_neg <= !above;
          if (div_start) begin
            state <= ST_WAIT;
          end else begin
            // Skipped division: the result is zero.
            unique case (phase)
              PH_X_AVG: begin
                xa    <= '0;
                phase <= PH_Y_AVG;
              end
              PH_Y_AVG: begin
                ya <= '0;
                if (run_mode) begin
                  state <= ST_FINISH;
                end else begin
                  phase <= PH_X_PCT;
                end
              end
              PH_X_PCT: begin
                xp    <= '0;
                phase <= PH_Y_PCT;
              end
              PH_Y_PCT: begin
                yp    <= '0;
                state <= ST_FINISH;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            state <= ST_LOAD;
            unique case (phase)
              PH_X_AVG: begin
                xa    <= div_quotient[7:0];
                phase <= PH_Y_AVG;
              end
              PH_Y_AVG: begin
                ya <= div_quotient[7:0];
                if (run_mode) begin
                  state <= ST_FINISH;
                end else begin
                  phase <= PH_X_PCT;
                end
              end
              PH_X_PCT: begin
                xp    <= pct_value;
                phase <= PH_Y_PCT;
              end
              PH_Y_PCT: begin
                yp    <= pct_value;
                state <= ST_FINISH;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            x_average       <= xa;
            y_average       <= ya;
            button_pressed  <= last_pressed;
            was_calibration <= run_mode;
            if (run_mode) begin
              x_zero_point <= xa;
              y_zero_point <= ya;
              x_percent    <= '0;
              y_percent    <= '0;
              direction    <= jac_pkg::DIR_NEUTRAL;
            end else begin
              x_percent <= xp;
              y_percent <= yp;
              direction <= dir_calc;
            end
            x_sum        <= '0;
            y_sum        <= '0;
            sample_count <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb_joystick_axis_conditioner_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for joystick_axis_conditioner_core: directed and random
// sample runs, with every result beat checked against an in-bench predictor.
// Depends on jac_pkg and the conditioner RTL.

module tb_joystick_axis_conditioner_core;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_REPORTS  = 10;
  localparam int ROUND_ITEMS  = 50;

  // One finished run as seen on the output channel.
  typedef struct {
    logic [7:0]        x_avg, y_avg;
    logic signed [7:0] x_pct, y_pct;
    logic [2:0]        dir;
    logic              pressed;
    logic              calib;
  } run_report_t;

  // Contents of the seven configuration registers.
  typedef struct {
    logic [7:0] avg_n, calib_n, x_lo, x_hi, y_lo, y_hi;
    logic [6:0] dz;
  } settings_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              func = 1'b0;
  logic [7:0]        x_sample = '0;
  logic [7:0]        y_sample = '0;
  logic              button_pin = 1'b1;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        x_average;
  logic [7:0]        y_average;
  logic signed [7:0] x_percent;
  logic signed [7:0] y_percent;
  logic [2:0]        direction;
  logic              button_pressed;
  logic              was_calibration;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [7:0]        cfg_data = '0;

  // Predictor state: register shadow, run accumulators and zero points.
  settings_t   cfg_shadow;
  logic [15:0] x_total, y_total;
  logic [7:0]  taken;
  logic        run_kind;
  logic [7:0]  x_center, y_center;
  run_report_t predicted_runs[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  joystick_axis_conditioner_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .x_sample(x_sample),
    .y_sample(y_sample),
    .button_pin(button_pin),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .x_average(x_average),
    .y_average(y_average),
    .x_percent(x_percent),
    .y_percent(y_percent),
    .direction(direction),
    .button_pressed(button_pressed),
    .was_calibration(was_calibration),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scale one axis average against its zero point and its end of travel.
  function automatic int scale_to_percent(int val, int zero, int lo, int hi);
    int span;
    int q;
    if (val >= zero) begin
      span = hi - zero;
      if (span <= 0) return 0;
      q = (val - zero) * int'(jac_pkg::PERCENT_SCALE) / span;
      return (q > int'(jac_pkg::PERCENT_MAX)) ? int'(jac_pkg::PERCENT_MAX) : q;
    end
    span = zero - lo;
    if (span <= 0) return 0;
    q = (zero - val) * int'(jac_pkg::PERCENT_SCALE) / span;
    return (q > int'(jac_pkg::PERCENT_MAX)) ? -int'(jac_pkg::PERCENT_MAX) : -q;
  endfunction

  // Deadzone classification; the x axis wins when both magnitudes are equal.
  function automatic logic [2:0] direction_of(int xp, int yp, int dz);
    int ay;
    ay = (yp >= 0) ? yp : -yp;
    if (xp > dz && xp >= ay) return jac_pkg::DIR_RIGHT;
    if (xp < -dz && -xp >= ay) return jac_pkg::DIR_LEFT;
    if (yp > dz) return jac_pkg::DIR_UP;
    if (yp < -dz) return jac_pkg::DIR_DOWN;
    return jac_pkg::DIR_NEUTRAL;
  endfunction

  // Add one accepted sample to the run; returns 1 with the report when it ends the run.
  function automatic bit accumulate_sample(input logic f, input logic [7:0] xs,
                                           input logic [7:0] ys, input logic pin,
                                           output run_report_t rep);
    logic [7:0] target;
    int xa = 0;
    int ya = 0;
    int xp = 0;
    int yp = 0;
    // A change of run kind throws away the partial sums.
    if (f != run_kind) begin
      run_kind = f;
      x_total  = '0;
      y_total  = '0;
      taken    = '0;
    end
    x_total = x_total + 16'(xs);
    y_total = y_total + 16'(ys);
    if (taken != 8'd255) taken = taken + 8'd1;
    target = run_kind ? cfg_shadow.calib_n : cfg_shadow.avg_n;
    if (target != 8'd0 && taken < target) return 1'b0;
    // A zero count ends every run with zero averages.
    if (target != 8'd0) begin
      xa = int'(x_total) / int'(taken);
      ya = int'(y_total) / int'(taken);
    end
    x_total = '0;
    y_total = '0;
    taken   = '0;
    rep.dir = jac_pkg::DIR_NEUTRAL;
    if (run_kind) begin
      x_center = xa[7:0];
      y_center = ya[7:0];
    end else begin
      xp = scale_to_percent(xa, int'(x_center), int'(cfg_shadow.x_lo),
                            int'(cfg_shadow.x_hi));
      yp = scale_to_percent(ya, int'(y_center), int'(cfg_shadow.y_lo),
                            int'(cfg_shadow.y_hi));
      rep.dir = direction_of(xp, yp, int'(cfg_shadow.dz));
    end
    rep.x_avg   = xa[7:0];
    rep.y_avg   = ya[7:0];
    rep.x_pct   = xp[7:0];
    rep.y_pct   = yp[7:0];
    rep.pressed = ~pin;
    rep.calib   = run_kind;
    return 1'b1;
  endfunction

  function automatic void note_mismatch(string what, int want_v, int got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want_v, got_v);
    end
  endfunction

  // Send one sample beat, with random idle cycles ahead of it.
  task automatic send_sample(input logic f, input logic [7:0] xs, input logic [7:0] ys,
                             input logic pin);
    run_report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    x_sample   <= xs;
    y_sample   <= ys;
    button_pin <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (accumulate_sample(f, xs, ys, pin, rep)) predicted_runs.push_back(rep);
    @(negedge clk);
  endtask

  // Stop sending, wait for every pending result and let a run-ending beat finish.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (predicted_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      jac_pkg::REG_UPDATE_COUNT:  cfg_shadow.avg_n   = data;
      jac_pkg::REG_CALIB_SAMPLES: cfg_shadow.calib_n = data;
      jac_pkg::REG_X_MINIMUM:     cfg_shadow.x_lo    = data;
      jac_pkg::REG_X_MAXIMUM:     cfg_shadow.x_hi    = data;
      jac_pkg::REG_Y_MINIMUM:     cfg_shadow.y_lo    = data;
      jac_pkg::REG_Y_MAXIMUM:     cfg_shadow.y_hi    = data;
      jac_pkg::REG_DEAD_ZONE:     cfg_shadow.dz      = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input settings_t s);
    write_register(jac_pkg::REG_UPDATE_COUNT, s.avg_n);
    write_register(jac_pkg::REG_CALIB_SAMPLES, s.calib_n);
    write_register(jac_pkg::REG_X_MINIMUM, s.x_lo);
    write_register(jac_pkg::REG_X_MAXIMUM, s.x_hi);
    write_register(jac_pkg::REG_Y_MINIMUM, s.y_lo);
    write_register(jac_pkg::REG_Y_MAXIMUM, s.y_hi);
    write_register(jac_pkg::REG_DEAD_ZONE, {1'b0, s.dz});
  endtask

  // Receiver side: random stall, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    run_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_runs.size() == 0) begin
        note_mismatch("unexpected result beat", 0, 1);
      end else begin
        want = predicted_runs.pop_front();
        if (x_average !== want.x_avg) note_mismatch("x_average", want.x_avg, x_average);
        if (y_average !== want.y_avg) note_mismatch("y_average", want.y_avg, y_average);
        if (x_percent !== want.x_pct) note_mismatch("x_percent", want.x_pct, x_percent);
        if (y_percent !== want.y_pct) note_mismatch("y_percent", want.y_pct, y_percent);
        if (direction !== want.dir) note_mismatch("direction", want.dir, direction);
        if (button_pressed !== want.pressed) begin
          note_mismatch("button_pressed", want.pressed, button_pressed);
        end
        if (was_calibration !== want.calib) begin
          note_mismatch("was_calibration", want.calib, was_calibration);
        end
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sample near a point, clipped to the converter range.
  function automatic logic [7:0] jitter(int base, int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 8'd0;
    if (r < 4) return 8'($urandom_range(40, 7));
    return 8'($urandom_range(6, 1));
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    int r;
    s.avg_n   = pick_count();
    s.calib_n = pick_count();
    // Mostly a sane stick; sometimes arbitrary ends, including inverted spans.
    if ($urandom_range(5) == 0) begin
      s.x_lo = 8'($urandom);
      s.x_hi = 8'($urandom);
      s.y_lo = 8'($urandom);
      s.y_hi = 8'($urandom);
    end else begin
      s.x_lo = 8'($urandom_range(110));
      s.x_hi = 8'($urandom_range(255, 150));
      s.y_lo = 8'($urandom_range(110));
      s.y_hi = 8'($urandom_range(255, 150));
    end
    r = $urandom_range(9);
    s.dz = (r == 0) ? 7'd0 : (r == 1) ? 7'd100 : (r == 2) ? 7'($urandom) :
           7'($urandom_range(40));
    return s;
  endfunction

  // Center the stick in a one-sample calibration run.
  task automatic test_center_calibration();
    settings_t s;
    settle_block();
    s = '{8'd1, 8'd1, jac_pkg::X_MINIMUM_RST, jac_pkg::X_MAXIMUM_RST,
          jac_pkg::Y_MINIMUM_RST, jac_pkg::Y_MAXIMUM_RST, jac_pkg::DEAD_ZONE_RST};
    apply_settings(s);
    send_sample(1'b1, 8'd128, 8'd128, 1'b0);
  endtask

  // Full deflection past both ends saturates; equal magnitudes go to x.
  task automatic test_saturation_and_ties();
    send_sample(1'b0, 8'd255, 8'd0, 1'b1);
    send_sample(1'b0, 8'd0, 8'd255, 1'b0);
    send_sample(1'b0, 8'd0, 8'd0, 1'b1);
  endtask

  task automatic test_vertical_directions();
    send_sample(1'b0, 8'd128, 8'd255, 1'b0);
    send_sample(1'b0, 8'd128, 8'd0, 1'b1);
  endtask

  // Ends on the wrong side of the zero point give a zero percent.
  task automatic test_span_not_positive();
    settings_t s;
    settle_block();
    s      = cfg_shadow;
    s.x_lo = 8'd200;
    s.x_hi = 8'd100;
    s.y_lo = 8'd0;
    s.y_hi = 8'd255;
    s.dz   = 7'd0;
    apply_settings(s);
    send_sample(1'b0, 8'd0, 8'd200, 1'b0);
    send_sample(1'b0, 8'd255, 8'd60, 1'b1);
  endtask

  // A deadzone of 100 or more keeps even full deflection neutral.
  task automatic test_deadzone_extremes();
    settings_t s;
    settle_block();
    s      = cfg_shadow;
    s.x_lo = 8'd0;
    s.x_hi = 8'd255;
    s.dz   = 7'd100;
    apply_settings(s);
    send_sample(1'b0, 8'd255, 8'd255, 1'b0);
    settle_block();
    s.dz = 7'd127;
    apply_settings(s);
    send_sample(1'b0, 8'd0, 8'd0, 1'b1);
  endtask

  // Zero counts end every run at once with zero averages.
  task automatic test_count_zero();
    settings_t s;
    settle_block();
    s         = cfg_shadow;
    s.avg_n   = 8'd0;
    s.calib_n = 8'd0;
    apply_settings(s);
    send_sample(1'b0, 8'd77, 8'd200, 1'b1);
    send_sample(1'b1, 8'd50, 8'd60, 1'b0);
    send_sample(1'b0, 8'd255, 8'd255, 1'b0);
  endtask

  // Lowering the count below the samples already taken ends the run on the next one.
  task automatic test_count_lowered();
    settings_t s;
    settle_block();
    s       = cfg_shadow;
    s.avg_n = 8'd5;
    apply_settings(s);
    send_sample(1'b0, 8'd10, 8'd250, 1'b1);
    send_sample(1'b0, 8'd30, 8'd240, 1'b1);
    send_sample(1'b0, 8'd50, 8'd230, 1'b0);
    settle_block();
    s.avg_n = 8'd2;
    apply_settings(s);
    send_sample(1'b0, 8'd71, 8'd201, 1'b0);
  endtask

  // Switching run kind mid-run restarts the sums.
  task automatic test_kind_change();
    settings_t s;
    settle_block();
    s         = cfg_shadow;
    s.avg_n   = 8'd4;
    s.calib_n = 8'd3;
    s.x_lo    = jac_pkg::X_MINIMUM_RST;
    s.x_hi    = jac_pkg::X_MAXIMUM_RST;
    s.dz      = jac_pkg::DEAD_ZONE_RST;
    apply_settings(s);
    send_sample(1'b0, 8'd255, 8'd255, 1'b1);
    send_sample(1'b0, 8'd255, 8'd255, 1'b1);
    send_sample(1'b1, 8'd120, 8'd140, 1'b1);
    send_sample(1'b1, 8'd130, 8'd150, 1'b0);
    send_sample(1'b1, 8'd141, 8'd131, 1'b1);
    send_sample(1'b0, 8'd200, 8'd100, 1'b0);
    send_sample(1'b0, 8'd210, 8'd90, 1'b1);
    send_sample(1'b0, 8'd220, 8'd80, 1'b0);
    send_sample(1'b0, 8'd230, 8'd70, 1'b1);
  endtask

  // Random runs under one idling mix; settings change between rounds.
  task automatic test_random_traffic(input int phase, input int sender_idle,
                                     input int receiver_stall);
    settings_t s;
    int        sent;
    int        run_len;
    int        kind;
    int        base_x;
    int        base_y;
    send_idle_pct = sender_idle;
    stall_pct     = receiver_stall;
    for (int rnd = 0; rnd < 5; rnd++) begin
      settle_block();
      s = random_settings();
      if (rnd == 0 && phase == 1) s.avg_n = 8'd255;
      if (rnd == 0 && phase == 2) s.calib_n = 8'd255;
      if (rnd == 1 && phase == 3) begin
        s.x_lo = 8'd0;
        s.x_hi = 8'd255;
        s.y_lo = 8'd0;
        s.y_hi = 8'd255;
      end
      apply_settings(s);
      sent = 0;
      while (sent < ROUND_ITEMS) begin
        kind = $urandom_range(19);
        if (kind < 3) begin
          // Calibration run with the stick resting near the middle.
          run_len = (s.calib_n == 8'd0) ? 1 : int'(s.calib_n);
          base_x  = $urandom_range(160, 96);
          base_y  = $urandom_range(160, 96);
          repeat (run_len) begin
            send_sample(1'b1, jitter(base_x, 6), jitter(base_y, 6), 1'($urandom));
          end
        end else if (kind < 5) begin
          // Short burst of arbitrary beats that breaks runs.
          run_len = $urandom_range(3, 1);
          repeat (run_len) begin
            send_sample(1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
          end
        end else begin
          // Update run with the stick held somewhere across its travel.
          run_len = (s.avg_n == 8'd0) ? 1 : int'(s.avg_n);
          base_x  = $urandom_range(255);
          base_y  = $urandom_range(255);
          repeat (run_len) begin
            send_sample(1'b0, jitter(base_x, 10), jitter(base_y, 10), 1'($urandom));
          end
        end
        sent += run_len;
      end
    end
  endtask

  initial begin
    cfg_shadow = '{jac_pkg::UPDATE_COUNT_RST, jac_pkg::CALIB_SAMPLES_RST,
                   jac_pkg::X_MINIMUM_RST, jac_pkg::X_MAXIMUM_RST,
                   jac_pkg::Y_MINIMUM_RST, jac_pkg::Y_MAXIMUM_RST,
                   jac_pkg::DEAD_ZONE_RST};
    x_total  = '0;
    y_total  = '0;
    taken    = '0;
    run_kind = 1'b0;
    x_center = '0;
    y_center = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_center_calibration();
    test_saturation_and_ties();
    test_vertical_directions();
    test_span_not_positive();
    test_deadzone_extremes();
    test_count_zero();
    test_count_lowered();
    test_kind_change();
    test_random_traffic(0, 0, 0);
    test_random_traffic(1, 72, 0);
    test_random_traffic(2, 0, 72);
    test_random_traffic(3, 12, 12);

    settle_block();
    if (mismatches == 0 && predicted_runs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/jac_pkg.sv
sv/jac_divider.sv
sv/joystick_axis_conditioner_core.sv
tb/tb_joystick_axis_conditioner_core.sv
